// File: sv/handshake_connection_fsm_defines.svh
// ----------------------------------------------------------------------------
// handshake connection fsm assertion macros
// shared property forms for the checks in the connection handshake rtl
// ----------------------------------------------------------------------------
`ifndef HANDSHAKE_CONNECTION_FSM_DEFINES_SVH
`define HANDSHAKE_CONNECTION_FSM_DEFINES_SVH

// condition implies consequence in the same cycle
`define HCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define HCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_pkg
// types, codes and reset values for the connection handshake block
// ----------------------------------------------------------------------------
package hcf_pkg;

    localparam logic [7:0] INIT_SEQ_RST = 8'd0;
    localparam logic [7:0] SYN_MASK_RST = 8'd1;
    localparam logic [7:0] ACK_MASK_RST = 8'd2;
    localparam logic [7:0] RST_MASK_RST = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE          = 3'd0,
        ST_SYN_SENT      = 3'd1,
        ST_SYNACK_QUEUED = 3'd2,
        ST_SYNACK_SENT   = 3'd3,
        ST_ACK_QUEUED    = 3'd4,
        ST_ACK_SENT      = 3'd5,
        ST_ESTABLISHED   = 3'd6,
        ST_RESET_QUEUED  = 3'd7
    } t_state;

    typedef enum logic [1:0] {
        KIND_SYN    = 2'd0,
        KIND_SYNACK = 2'd1,
        KIND_ACK    = 2'd2,
        KIND_RESET  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_CONNECT = 2'd1,
        CMD_SENT    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_INIT_SEQ = 2'd0,
        REG_SYN_MASK = 2'd1,
        REG_ACK_MASK = 2'd2,
        REG_RST_MASK = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] syn_mask;
        logic [7:0] ack_mask;
        logic [7:0] rst_mask;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic [7:0] value;
    } t_seq_load;

    typedef struct packed {
        logic [1:0] command;
        logic       header_complete;
        logic [7:0] rx_flags;
        logic [7:0] rx_sequence;
        logic [7:0] rx_acknowledge;
        logic [1:0] sent_kind;
    } t_item;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_flags;
        logic [7:0] send_sequence;
        logic [7:0] send_acknowledge;
        logic [1:0] send_kind;
        logic       wrong_state_error;
        logic [2:0] link_state;
    } t_result;

endpackage

// File: sv/hcf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_cfg
// flag mask registers and local sequence load from the write port
// ----------------------------------------------------------------------------
module hcf_cfg
    import hcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    output t_cfg       o_cfg,
    output t_seq_load  o_seq_load
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg            = r_cfg;
        o_seq_load.load  = 1'b0;
        o_seq_load.value = i_cfg_wdata;
        if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_INIT_SEQ: o_seq_load.load = 1'b1;
                REG_SYN_MASK: n_cfg.syn_mask  = i_cfg_wdata;
                REG_ACK_MASK: n_cfg.ack_mask  = i_cfg_wdata;
                REG_RST_MASK: n_cfg.rst_mask  = i_cfg_wdata;
                default:      n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.syn_mask <= SYN_MASK_RST;
            r_cfg.ack_mask <= ACK_MASK_RST;
            r_cfg.rst_mask <= RST_MASK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/hcf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcf_engine
// connection state, sequence numbers and the per-event decision logic
// ----------------------------------------------------------------------------
module hcf_engine
    import hcf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    input  t_seq_load i_seq_load,
    output t_result   o_result
);

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_local;
    logic [7:0] n_local;
    logic [7:0] r_remote;
    logic [7:0] n_remote;
    logic [7:0] w_next_local;
    logic [7:0] w_rx_next;
    logic [7:0] w_synack;
    t_result    w_res;

    assign w_next_local = r_local + 8'd1;
    assign w_rx_next    = i_item.rx_sequence + 8'd1;
    assign w_synack     = i_cfg.syn_mask | i_cfg.ack_mask;

    always_comb begin
        n_state  = r_state;
        n_local  = r_local;
        n_remote = r_remote;
        w_res    = '0;
        unique case (t_cmd'(i_item.command))
            CMD_HEADER: begin
                if (i_item.header_complete) begin
                    if ((i_item.rx_flags & i_cfg.rst_mask) != 8'd0) begin
                        n_state = ST_IDLE;
                    end else begin
                        case (r_state)
                            ST_IDLE: begin
                                if (i_item.rx_flags == i_cfg.syn_mask) begin
                                    n_remote               = i_item.rx_sequence;
                                    w_res.send_valid       = 1'b1;
                                    w_res.send_flags       = w_synack;
                                    w_res.send_sequence    = r_local;
                                    w_res.send_acknowledge = w_rx_next;
                                    w_res.send_kind        = KIND_SYNACK;
                                    n_state                = ST_SYNACK_QUEUED;
                                end
                            end
                            ST_SYN_SENT: begin
                                if (i_item.rx_flags == w_synack) begin
                                    n_remote         = i_item.rx_sequence;
                                    w_res.send_valid = 1'b1;
                                    if (i_item.rx_acknowledge == w_next_local) begin
                                        n_local                = w_next_local;
                                        w_res.send_flags       = i_cfg.ack_mask;
                                        w_res.send_sequence    = w_next_local;
                                        w_res.send_acknowledge = w_rx_next;
                                        w_res.send_kind        = KIND_ACK;
                                        n_state                = ST_ACK_QUEUED;
                                    end else begin
                                        w_res.send_flags    = i_cfg.rst_mask;
                                        w_res.send_sequence = r_local;
                                        w_res.send_kind     = KIND_RESET;
                                        n_state             = ST_IDLE;
                                    end
                                end else if (i_item.rx_flags == i_cfg.syn_mask) begin
                                    w_res.send_valid    = 1'b1;
                                    w_res.send_flags    = i_cfg.rst_mask;
                                    w_res.send_sequence = r_local;
                                    w_res.send_kind     = KIND_RESET;
                                    n_state             = ST_IDLE;
                                end
                            end
                            ST_SYNACK_SENT: begin
                                w_res.send_valid    = 1'b1;
                                w_res.send_sequence = r_local;
                                if (i_item.rx_flags == i_cfg.syn_mask) begin
                                    n_remote               = i_item.rx_sequence;
                                    w_res.send_flags       = w_synack;
                                    w_res.send_acknowledge = w_rx_next;
                                    w_res.send_kind        = KIND_SYNACK;
                                    n_state                = ST_SYNACK_QUEUED;
                                end else if (i_item.rx_flags == i_cfg.ack_mask &&
                                             i_item.rx_acknowledge == w_next_local) begin
                                    // final ack of the handshake, nothing to send
                                    w_res.send_valid    = 1'b0;
                                    w_res.send_sequence = 8'd0;
                                    n_state             = ST_ESTABLISHED;
                                end else begin
                                    w_res.send_flags = i_cfg.rst_mask;
                                    w_res.send_kind  = KIND_RESET;
                                    n_state          = ST_IDLE;
                                end
                            end
                            default: n_state = r_state;
                        endcase
                    end
                end
            end
            CMD_CONNECT: begin
                if (r_state == ST_IDLE) begin
                    w_res.send_valid    = 1'b1;
                    w_res.send_flags    = i_cfg.syn_mask;
                    w_res.send_sequence = r_local;
                    w_res.send_kind     = KIND_SYN;
                    n_state             = ST_SYN_SENT;
                end else begin
                    w_res.wrong_state_error = 1'b1;
                end
            end
            CMD_SENT: begin
                case (t_kind'(i_item.sent_kind))
                    KIND_SYNACK: n_state = ST_SYNACK_SENT;
                    KIND_ACK:    n_state = ST_ACK_SENT;
                    KIND_RESET:  n_state = ST_IDLE;
                    default:     n_state = r_state;
                endcase
            end
            default: n_state = r_state;
        endcase
        w_res.link_state = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_local  <= INIT_SEQ_RST;
            r_remote <= 8'd0;
        end else if (i_seq_load.load) begin
            r_local <= i_seq_load.value;
        end else if (i_fire) begin
            r_state  <= n_state;
            r_local  <= n_local;
            r_remote <= n_remote;
        end
    end

    assign o_result = w_res;

endmodule

// File: sv/handshake_connection_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handshake_connection_fsm
// three-way connection handshake for one peer with 8-bit sequence numbers
// ----------------------------------------------------------------------------
// Takes one event word per clock (received header, connect request or
// send-complete) while the master side keeps up, and returns exactly one
// result word per event: the header packet to send, if any, the connect error
// flag and the link state after the event. An event waits in the input
// register, where the decision logic reads it together with the connection
// state, and the result lands in the output register at the same edge that
// updates the state; the sustained rate is one event per cycle while the
// master side keeps up, set by the state update loop. A full output
// register holds while the master side stalls, and the input register then
// takes the next word only while it is empty. Configuration writes land at
// once and are meant for the idle block; writing register 0 also reloads the
// local sequence number.
`include "handshake_connection_fsm_defines.svh"

module handshake_connection_fsm
    import hcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] header_complete, [8:1] rx_flags, [16:9] rx_sequence,
    // [24:17] rx_acknowledge, [26:25] sent_kind, [31:27] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] send_valid, [8:1] send_flags, [16:9] send_sequence,
    // [24:17] send_acknowledge, [26:25] send_kind, [27] wrong_state_error,
    // [30:28] link_state, [31] zero
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    logic      r_in_valid;
    t_item     r_in;
    logic      r_out_valid;
    t_result   r_out;
    logic      w_in_fire;
    logic      w_advance;
    t_cfg      w_cfg;
    t_seq_load w_seq_load;
    t_result   w_result;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    hcf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg),
        .o_seq_load  (w_seq_load)
    );

    hcf_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_advance),
        .i_item     (r_in),
        .i_cfg      (w_cfg),
        .i_seq_load (w_seq_load),
        .o_result   (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in.command         <= s_axis_tuser;
            r_in.header_complete <= s_axis_tdata[0];
            r_in.rx_flags        <= s_axis_tdata[8:1];
            r_in.rx_sequence     <= s_axis_tdata[16:9];
            r_in.rx_acknowledge  <= s_axis_tdata[24:17];
            r_in.sent_kind       <= s_axis_tdata[26:25];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.link_state, r_out.wrong_state_error,
                            r_out.send_kind, r_out.send_acknowledge,
                            r_out.send_sequence, r_out.send_flags,
                            r_out.send_valid};

    `HCF_ASSERT_SAME(a_err_no_send, r_out_valid && r_out.wrong_state_error,
        !r_out.send_valid, "connect error word also carries a packet")
    `HCF_ASSERT_SAME(a_idle_fields_zero, r_out_valid && !r_out.send_valid,
        r_out.send_flags == 8'd0 && r_out.send_sequence == 8'd0 &&
        r_out.send_acknowledge == 8'd0 && r_out.send_kind == KIND_SYN,
        "packet fields not cleared without a packet")
    `HCF_ASSERT_SAME(a_reset_goes_idle,
        r_out_valid && r_out.send_valid && r_out.send_kind == KIND_RESET,
        r_out.link_state == ST_IDLE && r_out.send_acknowledge == 8'd0,
        "reset packet without return to idle")
    `HCF_ASSERT_NEXT(a_advance_fills_out, w_advance, r_out_valid,
        "event advanced but no result word held")
    `HCF_ASSERT_SAME(a_ready_when_empty, !r_in_valid, s_axis_tready,
        "input register empty but not ready")

endmodule

// File: tb/sv/tb_handshake_connection_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handshake_connection_fsm
// self-checking bench for the three-way connection handshake block
// ----------------------------------------------------------------------------
// Event words go in on the slave stream and every accepted word is run
// through a local copy of the handshake state machine, which queues the
// reply word it should cause. Reply words on the master stream are checked
// field by field against that queue in order. A short table of directed
// events walks every command, state transition, the flag precedence and the
// sequence wrap; after it, runs of mostly well-formed handshakes with random
// content follow, under several mask and initial-sequence settings and with
// sender gaps and receiver stalls switched on and off per phase.
// ----------------------------------------------------------------------------
module tb_handshake_connection_fsm;
    import hcf_pkg::*;

    localparam int          PER_PHASE   = 205;
    localparam int          N_PHASE     = 8;
    localparam int          N_PROBE     = 26;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;

    localparam logic [1:0]  IDLE_NONE = 2'd0;
    localparam logic [1:0]  IDLE_SEND = 2'd1;
    localparam logic [1:0]  IDLE_RECV = 2'd2;
    localparam logic [1:0]  IDLE_BOTH = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic       cmpl;
        logic [7:0] flags;
        logic [7:0] seq;
        logic [7:0] ack;
        logic [1:0] kind;
        logic       typed;
        t_result    want;
    } t_probe;

    typedef struct packed {
        logic [7:0] init_seq;
        logic [7:0] syn;
        logic [7:0] ack;
        logic [7:0] rst;
        logic [1:0] mode;
        logic       rnd;
    } t_setting;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    // [0] header_complete, [8:1] rx_flags, [16:9] rx_sequence,
    // [24:17] rx_acknowledge, [26:25] sent_kind, [31:27] zero
    logic [31:0] s_axis_tdata   = '0;
    // [1:0] command
    logic [1:0]  s_axis_tuser   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    // [0] send_valid, [8:1] send_flags, [16:9] send_sequence,
    // [24:17] send_acknowledge, [26:25] send_kind, [27] wrong_state_error,
    // [30:28] link_state, [31] zero
    logic [31:0] m_axis_tdata;
    logic        i_cfg_wr_en    = 1'b0;
    logic [1:0]  i_cfg_addr     = '0;
    logic [7:0]  i_cfg_wdata    = '0;

    // mirror of the block's state and registers
    t_state     link     = ST_IDLE;
    logic [7:0] loc_seq  = INIT_SEQ_RST;
    logic [7:0] rem_seq  = 8'd0;
    logic [7:0] syn_m    = SYN_MASK_RST;
    logic [7:0] ack_m    = ACK_MASK_RST;
    logic [7:0] rst_m    = RST_MASK_RST;

    t_result    reply_q [$];
    logic [1:0] idle_mode     = IDLE_NONE;
    int         mismatch_cnt  = 0;
    int         cycle_cnt     = 0;

    // group comments say what each run of words exercises, with default masks
    t_probe probe_tab [N_PROBE] = '{
        // connect from idle, then again while syn is out
        '{CMD_CONNECT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYN, 1'b1,
          '{1'b1, 8'h01, 8'h00, 8'h00, KIND_SYN, 1'b0, ST_SYN_SENT}},
        '{CMD_CONNECT, 1'b1, 8'hFF, 8'hFF, 8'hFF, KIND_RESET, 1'b1,
          '{1'b0, 8'h00, 8'h00, 8'h00, 2'b00, 1'b1, ST_SYN_SENT}},
        // good syn-ack, ack queued, ack sent
        '{CMD_HEADER, 1'b1, 8'h03, 8'h80, 8'h01, KIND_SYN, 1'b0, '0},
        '{CMD_SENT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_ACK, 1'b0, '0},
        // reset flag wins, incomplete header ignored
        '{CMD_HEADER, 1'b1, 8'hFF, 8'h00, 8'h00, KIND_SYN, 1'b1,
          '{1'b0, 8'h00, 8'h00, 8'h00, 2'b00, 1'b0, ST_IDLE}},
        '{CMD_HEADER, 1'b0, 8'h01, 8'h22, 8'h00, KIND_SYN, 1'b1,
          '{1'b0, 8'h00, 8'h00, 8'h00, 2'b00, 1'b0, ST_IDLE}},
        // passive open, remote+1 wraps to zero
        '{CMD_HEADER, 1'b1, 8'h01, 8'hFF, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_SENT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYNACK, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h02, 8'h00, 8'h02, KIND_SYN, 1'b0, '0},
        '{CMD_SENT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h01, 8'h00, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_CONNECT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYN, 1'b1,
          '{1'b0, 8'h00, 8'h00, 8'h00, 2'b00, 1'b1, ST_ESTABLISHED}},
        '{CMD_SENT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_RESET, 1'b0, '0},
        // simultaneous open answered with reset
        '{CMD_CONNECT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h01, 8'h44, 8'h00, KIND_SYN, 1'b0, '0},
        // syn-ack with a bad acknowledgement
        '{CMD_CONNECT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h03, 8'h55, 8'h00, KIND_SYN, 1'b0, '0},
        // unrelated flags ignored in syn sent, unused command does nothing
        '{CMD_CONNECT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h00, 8'h00, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF, KIND_RESET, 1'b1,
          '{1'b0, 8'h00, 8'h00, 8'h00, 2'b00, 1'b0, ST_SYN_SENT}},
        // syn-ack sent: repeated syn, bad ack, stray flags
        '{CMD_SENT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYNACK, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h01, 8'h10, 8'h00, KIND_SYN, 1'b0, '0},
        '{CMD_SENT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYNACK, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h02, 8'h00, 8'h07, KIND_SYN, 1'b0, '0},
        '{CMD_SENT, 1'b0, 8'h00, 8'h00, 8'h00, KIND_SYNACK, 1'b0, '0},
        '{CMD_HEADER, 1'b1, 8'h08, 8'h00, 8'h00, KIND_SYN, 1'b0, '0}
    };

    t_setting phase_tab [N_PHASE] = '{
        '{INIT_SEQ_RST, SYN_MASK_RST, ACK_MASK_RST, RST_MASK_RST, IDLE_NONE, 1'b0},
        '{8'hFF, 8'h01, 8'h10, 8'h80, IDLE_SEND, 1'b0},
        '{8'h00, 8'h80, 8'h40, 8'h01, IDLE_RECV, 1'b0},
        '{8'h3C, 8'hFF, 8'h00, 8'h00, IDLE_BOTH, 1'b0},
        '{8'h00, 8'h00, 8'hFF, 8'hFF, IDLE_BOTH, 1'b0},
        '{8'h00, 8'h00, 8'h00, 8'h00, IDLE_NONE, 1'b1},
        '{8'h5A, 8'h20, 8'h04, 8'h02, IDLE_SEND, 1'b0},
        '{8'h80, 8'h01, 8'h02, 8'h04, IDLE_RECV, 1'b0}
    };

    handshake_connection_fsm u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_result pkt(input logic [7:0] flags, input logic [7:0] seq,
                                    input logic [7:0] ack, input t_kind kind);
        t_result r;
        r                  = '0;
        r.send_valid       = 1'b1;
        r.send_flags       = flags;
        r.send_sequence    = seq;
        r.send_acknowledge = ack;
        r.send_kind        = kind;
        return r;
    endfunction

    // reset packet, the link drops straight back to idle
    function automatic t_result abort_link();
        link = ST_IDLE;
        return pkt(rst_m, loc_seq, 8'd0, KIND_RESET);
    endfunction

    function automatic t_result handshake_step(input t_item it);
        t_result    r;
        logic [7:0] nxt;
        r   = '0;
        nxt = loc_seq + 8'd1;
        case (it.command)
            CMD_HEADER: begin
                if (it.header_complete) begin
                    if ((it.rx_flags & rst_m) != 8'd0) begin
                        link = ST_IDLE;
                    end else begin
                        case (link)
                            ST_IDLE: begin
                                if (it.rx_flags == syn_m) begin
                                    rem_seq = it.rx_sequence;
                                    r = pkt(syn_m | ack_m, loc_seq, rem_seq + 8'd1,
                                            KIND_SYNACK);
                                    link = ST_SYNACK_QUEUED;
                                end
                            end
                            ST_SYN_SENT: begin
                                if (it.rx_flags == (syn_m | ack_m)) begin
                                    rem_seq = it.rx_sequence;
                                    if (it.rx_acknowledge == nxt) begin
                                        loc_seq = nxt;
                                        r = pkt(ack_m, loc_seq, rem_seq + 8'd1, KIND_ACK);
                                        link = ST_ACK_QUEUED;
                                    end else begin
                                        r = abort_link();
                                    end
                                end else if (it.rx_flags == syn_m) begin
                                    r = abort_link();
                                end
                            end
                            ST_SYNACK_SENT: begin
                                if (it.rx_flags == syn_m) begin
                                    rem_seq = it.rx_sequence;
                                    r = pkt(syn_m | ack_m, loc_seq, rem_seq + 8'd1,
                                            KIND_SYNACK);
                                    link = ST_SYNACK_QUEUED;
                                end else if (it.rx_flags == ack_m &&
                                             it.rx_acknowledge == nxt) begin
                                    link = ST_ESTABLISHED;
                                end else begin
                                    r = abort_link();
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_CONNECT: begin
                if (link == ST_IDLE) begin
                    r = pkt(syn_m, loc_seq, 8'd0, KIND_SYN);
                    link = ST_SYN_SENT;
                end else begin
                    r.wrong_state_error = 1'b1;
                end
            end
            CMD_SENT: begin
                case (it.sent_kind)
                    KIND_SYNACK: link = ST_SYNACK_SENT;
                    KIND_ACK:    link = ST_ACK_SENT;
                    KIND_RESET:  link = ST_IDLE;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.link_state = link;
        return r;
    endfunction

    // mostly the next legal step of a handshake, with some noise mixed in
    function automatic t_item pick_event();
        t_item       it;
        int unsigned dice;
        it.command         = CMD_HEADER;
        it.header_complete = 1'b1;
        it.rx_flags        = 8'($urandom_range(0, 255));
        it.rx_sequence     = 8'($urandom_range(0, 255));
        it.rx_acknowledge  = 8'($urandom_range(0, 255));
        it.sent_kind       = 2'($urandom_range(0, 3));
        dice = $urandom_range(0, 99);
        if (dice < 15) begin
            it.command         = 2'($urandom_range(0, 3));
            it.header_complete = 1'($urandom_range(0, 1));
            return it;
        end
        case (link)
            ST_IDLE: begin
                if (dice < 60)
                    it.command = CMD_CONNECT;
                else
                    it.rx_flags = syn_m;
            end
            ST_SYN_SENT: begin
                if (dice < 85) begin
                    it.rx_flags = syn_m | ack_m;
                    if (dice < 75)
                        it.rx_acknowledge = loc_seq + 8'd1;
                end else if (dice < 92) begin
                    it.rx_flags = syn_m;
                end else begin
                    it.command   = CMD_SENT;
                    it.sent_kind = KIND_SYN;
                end
            end
            ST_SYNACK_QUEUED: begin
                it.command   = CMD_SENT;
                it.sent_kind = KIND_SYNACK;
            end
            ST_ACK_QUEUED: begin
                it.command   = CMD_SENT;
                it.sent_kind = KIND_ACK;
            end
            ST_SYNACK_SENT: begin
                if (dice < 75) begin
                    it.rx_flags       = ack_m;
                    it.rx_acknowledge = loc_seq + 8'd1;
                end else if (dice < 88) begin
                    it.rx_flags = syn_m;
                end
            end
            default: begin
                if (dice < 40) begin
                    it.command = CMD_CONNECT;
                end else if (dice < 70) begin
                    it.command   = CMD_SENT;
                    it.sent_kind = KIND_RESET;
                end else begin
                    it.rx_flags = rst_m;
                end
            end
        endcase
        return it;
    endfunction

    function automatic bit sender_gap();
        if (idle_mode == IDLE_SEND)
            return $urandom_range(0, 99) < 81;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 34;
        return 1'b0;
    endfunction

    task automatic push_event(input t_item it, input bit use_typed, input t_result typed_res);
        t_result pred;
        while (sender_gap()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, it.sent_kind, it.rx_acknowledge, it.rx_sequence,
                          it.rx_flags, it.header_complete};
        s_axis_tuser  <= it.command;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pred = handshake_step(it);
        reply_q.insert(reply_q.size(), use_typed ? typed_res : pred);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [7:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_INIT_SEQ: begin
                loc_seq  = val;
            end
            REG_SYN_MASK: syn_m = val;
            REG_ACK_MASK: ack_m = val;
            REG_RST_MASK: rst_m = val;
            default: ;
        endcase
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reply_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %s: expected 0x%02h, got 0x%02h at %0t", what, want, got,
                     $realtime);
    endtask

    always @(posedge i_clk) begin
        if (idle_mode == IDLE_RECV)
            m_axis_tready <= $urandom_range(0, 99) >= 81;
        else if (idle_mode == IDLE_BOTH)
            m_axis_tready <= $urandom_range(0, 99) >= 34;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin : reply_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reply_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected reply word 0x%08h at %0t", m_axis_tdata, $realtime);
            end else begin
                want = reply_q.pop_front();
                if (m_axis_tdata[0] !== want.send_valid)
                    note_mismatch("send_valid", 8'(want.send_valid), 8'(m_axis_tdata[0]));
                if (m_axis_tdata[8:1] !== want.send_flags)
                    note_mismatch("send_flags", want.send_flags, m_axis_tdata[8:1]);
                if (m_axis_tdata[16:9] !== want.send_sequence)
                    note_mismatch("send_sequence", want.send_sequence, m_axis_tdata[16:9]);
                if (m_axis_tdata[24:17] !== want.send_acknowledge)
                    note_mismatch("send_acknowledge", want.send_acknowledge,
                                  m_axis_tdata[24:17]);
                if (m_axis_tdata[26:25] !== want.send_kind)
                    note_mismatch("send_kind", 8'(want.send_kind), 8'(m_axis_tdata[26:25]));
                if (m_axis_tdata[27] !== want.wrong_state_error)
                    note_mismatch("wrong_state_error", 8'(want.wrong_state_error),
                                  8'(m_axis_tdata[27]));
                if (m_axis_tdata[30:28] !== want.link_state)
                    note_mismatch("link_state", 8'(want.link_state), 8'(m_axis_tdata[30:28]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL handshake_connection_fsm");
            $finish;
        end
    end

    initial begin : stimulus
        t_item    it;
        t_setting s;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < N_PHASE; p++) begin
            s = phase_tab[p];
            if (s.rnd) begin
                s.init_seq = 8'($urandom_range(0, 255));
                s.syn      = 8'($urandom_range(0, 255));
                s.ack      = 8'($urandom_range(0, 255));
                s.rst      = 8'($urandom_range(0, 255));
            end
            if (p > 0) begin
                drain_replies();
                write_reg(REG_INIT_SEQ, s.init_seq);
                write_reg(REG_SYN_MASK, s.syn);
                write_reg(REG_ACK_MASK, s.ack);
                write_reg(REG_RST_MASK, s.rst);
                i_cfg_wr_en <= 1'b0;
            end
            idle_mode = s.mode;
            if (p == 0) begin
                foreach (probe_tab[k]) begin
                    it.command         = probe_tab[k].cmd;
                    it.header_complete = probe_tab[k].cmpl;
                    it.rx_flags        = probe_tab[k].flags;
                    it.rx_sequence     = probe_tab[k].seq;
                    it.rx_acknowledge  = probe_tab[k].ack;
                    it.sent_kind       = probe_tab[k].kind;
                    push_event(it, probe_tab[k].typed, probe_tab[k].want);
                end
            end
            for (int n = 0; n < PER_PHASE; n++)
                push_event(pick_event(), 1'b0, '0);
        end
        drain_replies();
        // let any stray reply word surface before the verdict
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && reply_q.size() == 0)
            $display("PASS handshake_connection_fsm");
        else
            $display("FAIL handshake_connection_fsm");
        $finish;
    end

endmodule
